// File: hw/rtl/pump_health_scorer_macros.svh
// Assertion helpers shared by phs_fifo, phs_front and phs_back.
`ifndef PUMP_HEALTH_SCORER_MACROS_SVH
`define PUMP_HEALTH_SCORER_MACROS_SVH

// Checked on every rising edge outside reset.
`define PHS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define PHS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hw/rtl/phs_pkg.sv
package phs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_PRESSURE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_WARN       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_CRIT       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_SHUTDOWN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_WARN    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_CRIT    = 3'd5;

    // Register reset values.
    localparam logic signed [14:0] TARGET_PRESSURE_RST = -15'sd8000;
    localparam logic signed [11:0] TEMP_WARN_RST       = 12'sd600;
    localparam logic signed [11:0] TEMP_CRIT_RST       = 12'sd750;
    localparam logic signed [11:0] TEMP_SHUTDOWN_RST   = 12'sd850;
    localparam logic [14:0]        CURRENT_WARN_RST    = 15'd4000;
    localparam logic [14:0]        CURRENT_CRIT_RST    = 15'd5000;

    // Request kinds.
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    // Maintenance levels.
    localparam logic [1:0] LVL_NONE     = 2'd0;
    localparam logic [1:0] LVL_SOON     = 2'd1;
    localparam logic [1:0] LVL_REQUIRED = 2'd2;
    localparam logic [1:0] LVL_URGENT   = 2'd3;

    localparam logic [13:0] SCORE_FULL = 14'd10000;
    localparam int OUT_DEPTH_LOG2 = 1;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic        func;
        logic [6:0]  vac_band;
        logic [6:0]  temp_band;
        logic [6:0]  cur_band;
        logic [6:0]  run_band;
        logic [15:0] overtemp_count;
        logic [15:0] overcurrent_count;
    } t_mid;

    typedef struct packed {
        logic [13:0] health_score;
        logic [1:0]  level;
        logic        alert;
    } t_res;

    function automatic logic [15:0] sat_add16(input logic [15:0] c, input logic [1:0] d);
        logic [16:0] s;
        s = {1'b0, c} + {15'd0, d};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// File: hw/rtl/phs_fifo.sv
`include "pump_health_scorer_macros.svh"

module phs_fifo import phs_pkg::*; #(
    parameter int WIDTH      = 1,
    parameter int DEPTH_LOG2 = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [DEPTH_LOG2:0] r_wr_ptr, n_wr_ptr;
    logic [DEPTH_LOG2:0] r_rd_ptr, n_rd_ptr;
    logic                do_push, do_pop;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[DEPTH_LOG2] != r_rd_ptr[DEPTH_LOG2]) &&
                     (r_wr_ptr[DEPTH_LOG2-1:0] == r_rd_ptr[DEPTH_LOG2-1:0]);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr[DEPTH_LOG2-1:0]];

    always_comb begin
        n_wr_ptr = r_wr_ptr + (DEPTH_LOG2+1)'(do_push);
        n_rd_ptr = r_rd_ptr + (DEPTH_LOG2+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr[DEPTH_LOG2-1:0]] <= i_data;
        end
    end

    `PHS_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> o_empty, "queue not empty after reset")
    `PHS_ASSERT(a_not_full_and_empty, !(o_full && o_empty), "queue full and empty")
    `PHS_ASSERT(a_push_fills, (i_push && !o_full) |=> !o_empty, "queue empty after push")

endmodule

// File: hw/rtl/phs_front.sv
`include "pump_health_scorer_macros.svh"

module phs_front import phs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_accept,
    input  logic                   i_func,
    input  logic signed [14:0]     i_pressure,
    input  logic signed [11:0]     i_temperature,
    input  logic [14:0]            i_motor_current,
    output t_mid                   o_entry
);

    logic signed [14:0] r_target_pressure;
    logic signed [11:0] r_temp_warn;
    logic signed [11:0] r_temp_crit;
    logic signed [11:0] r_temp_shutdown;
    logic [14:0]        r_current_warn;
    logic [14:0]        r_current_crit;

    logic [31:0] r_run_count, n_run_count;
    logic [15:0] r_overtemp_count, n_overtemp_count;
    logic [15:0] r_overcurrent_count, n_overcurrent_count;

    logic [14:0] mag_p, mag_t;
    logic [21:0] a100, b95, b90, b85, b80, b70;
    logic [6:0]  vac_band, temp_band, cur_band, run_band;
    logic [1:0]  temp_add, cur_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_pressure <= TARGET_PRESSURE_RST;
            r_temp_warn       <= TEMP_WARN_RST;
            r_temp_crit       <= TEMP_CRIT_RST;
            r_temp_shutdown   <= TEMP_SHUTDOWN_RST;
            r_current_warn    <= CURRENT_WARN_RST;
            r_current_crit    <= CURRENT_CRIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_TARGET_PRESSURE: r_target_pressure <= i_cfg_data;
                REG_TEMP_WARN:       r_temp_warn       <= i_cfg_data[11:0];
                REG_TEMP_CRIT:       r_temp_crit       <= i_cfg_data[11:0];
                REG_TEMP_SHUTDOWN:   r_temp_shutdown   <= i_cfg_data[11:0];
                REG_CURRENT_WARN:    r_current_warn    <= i_cfg_data;
                REG_CURRENT_CRIT:    r_current_crit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The vacuum ratio is graded by cross-multiplication against the target.
    always_comb begin
        mag_p = i_pressure[14] ? 15'(-i_pressure) : 15'(i_pressure);
        mag_t = r_target_pressure[14] ? 15'(-r_target_pressure) : 15'(r_target_pressure);
        a100  = 22'(mag_p) * 22'd100;
        b95   = 22'(mag_t) * 22'd95;
        b90   = 22'(mag_t) * 22'd90;
        b85   = 22'(mag_t) * 22'd85;
        b80   = 22'(mag_t) * 22'd80;
        b70   = 22'(mag_t) * 22'd70;
        if (mag_t == 15'd0)  vac_band = 7'd100;
        else if (a100 >= b95) vac_band = 7'd100;
        else if (a100 >= b90) vac_band = 7'd90;
        else if (a100 >= b85) vac_band = 7'd80;
        else if (a100 >= b80) vac_band = 7'd70;
        else if (a100 >= b70) vac_band = 7'd60;
        else                  vac_band = 7'd50;
    end

    always_comb begin
        if (i_temperature < r_temp_warn) begin
            temp_band = 7'd100;
            temp_add  = 2'd0;
        end else if (i_temperature < r_temp_crit) begin
            temp_band = 7'd80;
            temp_add  = 2'd1;
        end else if (i_temperature < r_temp_shutdown) begin
            temp_band = 7'd60;
            temp_add  = 2'd2;
        end else begin
            temp_band = 7'd40;
            temp_add  = 2'd3;
        end

        if (i_motor_current < r_current_warn) begin
            cur_band = 7'd100;
            cur_add  = 2'd0;
        end else if (i_motor_current < r_current_crit) begin
            cur_band = 7'd80;
            cur_add  = 2'd1;
        end else begin
            cur_band = 7'd60;
            cur_add  = 2'd2;
        end

        if (r_run_count < 32'd1000)       run_band = 7'd100;
        else if (r_run_count < 32'd5000)  run_band = 7'd90;
        else if (r_run_count < 32'd10000) run_band = 7'd80;
        else if (r_run_count < 32'd20000) run_band = 7'd70;
        else                              run_band = 7'd60;
    end

    always_comb begin
        n_run_count         = r_run_count;
        n_overtemp_count    = r_overtemp_count;
        n_overcurrent_count = r_overcurrent_count;
        if (i_func == FUNC_CLEAR) begin
            n_overtemp_count    = 16'd0;
            n_overcurrent_count = 16'd0;
        end else begin
            n_overtemp_count    = sat_add16(r_overtemp_count, temp_add);
            n_overcurrent_count = sat_add16(r_overcurrent_count, cur_add);
            if (r_run_count != 32'hFFFF_FFFF) begin
                n_run_count = r_run_count + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count         <= '0;
            r_overtemp_count    <= '0;
            r_overcurrent_count <= '0;
        end else if (i_accept) begin
            r_run_count         <= n_run_count;
            r_overtemp_count    <= n_overtemp_count;
            r_overcurrent_count <= n_overcurrent_count;
        end
    end

    // The back end needs the counters as they stand after this request.
    always_comb begin
        o_entry.func              = i_func;
        o_entry.vac_band          = vac_band;
        o_entry.temp_band         = temp_band;
        o_entry.cur_band          = cur_band;
        o_entry.run_band          = run_band;
        o_entry.overtemp_count    = n_overtemp_count;
        o_entry.overcurrent_count = n_overcurrent_count;
    end

    `PHS_ASSERT(a_state_holds_when_idle, !i_accept |=> ($stable(r_run_count) && $stable(r_overtemp_count) && $stable(r_overcurrent_count)), "counters moved without a request")

endmodule

// File: hw/rtl/phs_back.sv
`include "pump_health_scorer_macros.svh"

module phs_back import phs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_mid i_entry,
    input  logic i_ready,
    output logic o_go,
    output t_res o_result
);

    logic [1:0]  r_prev_level, n_prev_level;
    logic [13:0] base;
    logic [24:0] penalty;
    logic [13:0] score;
    logic [1:0]  lvl;

    assign o_go = i_valid && i_ready;

    always_comb begin
        base = 14'(i_entry.vac_band) * 14'd35 + 14'(i_entry.temp_band) * 14'd25 +
               14'(i_entry.cur_band) * 14'd25 + 14'(i_entry.run_band) * 14'd15;
        penalty = 25'(i_entry.overtemp_count) * 25'd200 +
                  25'(i_entry.overcurrent_count) * 25'd150;
        // The score clamps at zero once the penalty reaches the band sum.
        score = (25'(base) > penalty) ? 14'(25'(base) - penalty) : 14'd0;

        if (score >= 14'd9000)      lvl = LVL_NONE;
        else if (score >= 14'd7500) lvl = LVL_SOON;
        else if (score >= 14'd6000) lvl = LVL_REQUIRED;
        else                        lvl = LVL_URGENT;

        if (i_entry.func == FUNC_CLEAR) begin
            o_result.health_score = SCORE_FULL;
            o_result.level        = LVL_NONE;
            o_result.alert        = 1'b0;
            n_prev_level          = LVL_NONE;
        end else begin
            o_result.health_score = score;
            o_result.level        = lvl;
            o_result.alert        = (lvl > r_prev_level) && (lvl != LVL_NONE);
            n_prev_level          = lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= LVL_NONE;
        end else if (o_go) begin
            r_prev_level <= n_prev_level;
        end
    end

    `PHS_ASSERT(a_clear_resets_level, (o_go && i_entry.func == FUNC_CLEAR) |=> (r_prev_level == LVL_NONE), "level kept after clear")
    `PHS_ASSERT(a_level_holds_when_idle, !o_go |=> $stable(r_prev_level), "level moved without a request")

endmodule

// File: hw/rtl/pump_health_scorer.sv
// Pump health scorer.
// Input channel: drive func, pressure, temperature and motor current with
// push high; a request is taken at a rising edge where push is high and full
// is low. Results leave through a queue: while empty is low the oldest score,
// level and alert are on the result ports, and pop at an edge takes them.
// A taken request enters the middle queue; the back scores it into the
// result queue. One request per cycle is sustained while full is low: the
// front grades it and updates the run and over-limit counters in the cycle
// it is taken, and the back turns one queued entry per cycle into a score
// and level while the result queue has room. If the receiver stops popping,
// the result queue fills, the back holds, the middle queue (MID_DEPTH_LOG2)
// fills behind it, and full rises; nothing is lost. Configuration writes
// take effect at the next edge and must be made by the user while the block
// is idle, which the block does not enforce. Synchronous reset restores
// register defaults, clears counters and level, and empties both queues.
module pump_health_scorer import phs_pkg::*; #(
    parameter int MID_DEPTH_LOG2 = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic                   i_func,
    input  logic signed [14:0]     i_pressure,
    input  logic signed [11:0]     i_temperature,
    input  logic [14:0]            i_motor_current,
    output logic                   empty,
    input  logic                   pop,
    output logic [13:0]            o_health_score,
    output logic [1:0]             o_level,
    output logic                   o_alert
);

    t_mid entry, mid_entry;
    t_res result, out_res;
    logic accept, mid_empty, back_go, out_full;

    assign accept = push && !full;

    phs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_func         (i_func),
        .i_pressure     (i_pressure),
        .i_temperature  (i_temperature),
        .i_motor_current(i_motor_current),
        .o_entry        (entry)
    );

    phs_fifo #(
        .WIDTH     ($bits(t_mid)),
        .DEPTH_LOG2(MID_DEPTH_LOG2)
    ) u_mid_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (entry),
        .o_full (full),
        .i_pop  (back_go),
        .o_data (mid_entry),
        .o_empty(mid_empty)
    );

    phs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!mid_empty),
        .i_entry (mid_entry),
        .i_ready (!out_full),
        .o_go    (back_go),
        .o_result(result)
    );

    phs_fifo #(
        .WIDTH     ($bits(t_res)),
        .DEPTH_LOG2(OUT_DEPTH_LOG2)
    ) u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (back_go),
        .i_data (result),
        .o_full (out_full),
        .i_pop  (pop),
        .o_data (out_res),
        .o_empty(empty)
    );

    assign o_health_score = out_res.health_score;
    assign o_level        = out_res.level;
    assign o_alert        = out_res.alert;

endmodule
